[rtl/command_slot_tracker_top_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the command slot tracker.
// Each module that checks itself includes this header and writes its
// properties with these macros; synthesis builds see empty bodies.
// ---------------------------------------------------------------------------
`ifndef COMMAND_SLOT_TRACKER_TOP_ASSERT_SVH
`define COMMAND_SLOT_TRACKER_TOP_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising clock edge out of reset.
`define CST_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("command slot tracker check failed");
// Next-cycle implication.
`define CST_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("command slot tracker check failed");
`else
`define CST_ASSERT_IMPL(lbl, ante, cons)
`define CST_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/cst_pkg.sv]
// ---------------------------------------------------------------------------
// Command slot tracker package
// Shared types, codes and reset values for the slot tracker modules.
// ---------------------------------------------------------------------------
package cst_pkg;

	// Largest number of slots the maps are built for.
	localparam int SLOT_LIMIT_DEF = 256;

	// Register reset values.
	localparam logic [8:0]  SLOT_COUNT_RST = 9'd256;
	localparam logic [16:0] SLOT_BYTES_RST = 17'd256;
	localparam logic [31:0] QUEUE_BASE_RST = 32'd0;
	localparam logic        DOORBELL_RST   = 1'b0;

	// Configuration register indexes (byte address = 4 * index).
	typedef enum logic [1:0] {
		REG_SLOT_COUNT = 2'd0,
		REG_SLOT_BYTES = 2'd1,
		REG_QUEUE_BASE = 2'd2,
		REG_DOORBELL   = 2'd3
	} cst_reg_t;

	// Transaction action codes.
	typedef enum logic [1:0] {
		ACT_ALLOC  = 2'd0,
		ACT_STATUS = 2'd1,
		ACT_CHECK  = 2'd2
	} cst_action_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PICK,
		ST_GRANT,
		ST_ADDR,
		ST_MERGE,
		ST_CHECK,
		ST_NOP
	} cst_state_t;

	// Input transaction payload.
	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  slot;
		logic [2:0]  word_index;
		logic [31:0] status_bits;
	} cst_item_t;

	// Result transaction payload.
	typedef struct packed {
		logic        ok;
		logic [7:0]  granted_slot;
		logic [31:0] header_address;
		logic [31:0] data_address;
		logic        doorbell_valid;
		logic [2:0]  doorbell_index;
		logic [31:0] doorbell_mask;
	} cst_result_t;

	// Configuration register contents.
	typedef struct packed {
		logic [8:0]  slot_count;
		logic [16:0] slot_bytes;
		logic [31:0] queue_base;
		logic        doorbell_enable;
	} cst_cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic pick;
		logic grant;
		logic addr;
		logic merge;
		logic check;
		logic nop;
	} cst_cmd_t;

endpackage

[rtl/cst_regs.sv]
// ---------------------------------------------------------------------------
// Command slot tracker register file
// APB-style configuration registers with read-back.
// ---------------------------------------------------------------------------
module cst_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cst_pkg::cst_cfg_t cfg
);

	logic              wr_en;
	cst_pkg::cst_reg_t reg_sel;
	cst_pkg::cst_cfg_t cfg_q;

	// The port never inserts wait states.
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_sel = cst_pkg::cst_reg_t'(paddr[3:2]);
	assign cfg     = cfg_q;

	// Register writes on the access phase of a write transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slot_count      <= cst_pkg::SLOT_COUNT_RST;
			cfg_q.slot_bytes      <= cst_pkg::SLOT_BYTES_RST;
			cfg_q.queue_base      <= cst_pkg::QUEUE_BASE_RST;
			cfg_q.doorbell_enable <= cst_pkg::DOORBELL_RST;
		end else if (wr_en) begin
			case (reg_sel)
				cst_pkg::REG_SLOT_COUNT: cfg_q.slot_count      <= pwdata[8:0];
				cst_pkg::REG_SLOT_BYTES: cfg_q.slot_bytes      <= pwdata[16:0];
				cst_pkg::REG_QUEUE_BASE: cfg_q.queue_base      <= pwdata;
				cst_pkg::REG_DOORBELL:   cfg_q.doorbell_enable <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read-back mux.
	always_comb begin
		case (reg_sel)
			cst_pkg::REG_SLOT_COUNT: prdata = {23'd0, cfg_q.slot_count};
			cst_pkg::REG_SLOT_BYTES: prdata = {15'd0, cfg_q.slot_bytes};
			cst_pkg::REG_QUEUE_BASE: prdata = cfg_q.queue_base;
			cst_pkg::REG_DOORBELL:   prdata = {31'd0, cfg_q.doorbell_enable};
			default:                 prdata = 32'd0;
		endcase
	end

endmodule

[rtl/cst_ctrl.sv]
// ---------------------------------------------------------------------------
// Command slot tracker controller
// Sequences each transaction through the datapath steps for its action.
// ---------------------------------------------------------------------------
module cst_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        action,
	output logic              busy,
	output cst_pkg::cst_cmd_t cmd
);

`include "command_slot_tracker_top_assert.svh"

	cst_pkg::cst_state_t state_q;
	cst_pkg::cst_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cst_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			cst_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					case (action)
						cst_pkg::ACT_ALLOC:  state_d = cst_pkg::ST_PICK;
						cst_pkg::ACT_STATUS: state_d = cst_pkg::ST_MERGE;
						cst_pkg::ACT_CHECK:  state_d = cst_pkg::ST_CHECK;
						default:             state_d = cst_pkg::ST_NOP;
					endcase
				end
			end
			cst_pkg::ST_PICK: begin
				cmd.pick = 1'b1;
				state_d  = cst_pkg::ST_GRANT;
			end
			cst_pkg::ST_GRANT: begin
				cmd.grant = 1'b1;
				state_d   = cst_pkg::ST_ADDR;
			end
			cst_pkg::ST_ADDR: begin
				cmd.addr = 1'b1;
				state_d  = cst_pkg::ST_IDLE;
			end
			cst_pkg::ST_MERGE: begin
				cmd.merge = 1'b1;
				state_d   = cst_pkg::ST_IDLE;
			end
			cst_pkg::ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = cst_pkg::ST_IDLE;
			end
			cst_pkg::ST_NOP: begin
				cmd.nop = 1'b1;
				state_d = cst_pkg::ST_IDLE;
			end
			default: begin
				state_d = cst_pkg::ST_IDLE;
			end
		endcase
	end

	// At most one datapath step is commanded per cycle.
	`CST_ASSERT_IMPL(a_cmd_onehot, 1'b1, $onehot0(cmd))
	// An accepted allocate transaction starts with the slot search.
	`CST_ASSERT_NEXT(a_alloc_picks, cmd.load && (action == cst_pkg::ACT_ALLOC), cmd.pick)

endmodule

[rtl/cst_dpath.sv]
// ---------------------------------------------------------------------------
// Command slot tracker datapath
// Holds the used and completion maps, searches for free slots and forms
// the result transactions.
// ---------------------------------------------------------------------------
module cst_dpath #(
	parameter int SLOT_LIMIT = cst_pkg::SLOT_LIMIT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cst_pkg::cst_cmd_t    cmd,
	input  cst_pkg::cst_cfg_t    cfg,
	input  cst_pkg::cst_item_t   item,
	output logic                 done,
	output cst_pkg::cst_result_t result
);

`include "command_slot_tracker_top_assert.svh"

	localparam int         MAP_WORDS = (SLOT_LIMIT + 31) / 32;
	localparam logic [8:0] MAX_N     = 9'(SLOT_LIMIT);

	typedef logic [MAP_WORDS-1:0][31:0] map_t;

	// Slot maps, one 32-bit word per group of 32 slots.
	map_t used_map_q;
	map_t cmpl_map_q;

	// Latched input transaction.
	cst_pkg::cst_item_t item_q;

	// Search pipeline.
	logic [2:0]  pick_word_s1;
	logic [31:0] pick_bits_s1;
	logic        pick_any_s1;
	logic [7:0]  grant_slot_s2;
	logic        grant_any_s2;
	logic [24:0] prod_s2;

	// Result register.
	cst_pkg::cst_result_t res_q;
	logic                 res_vld_q;

	logic [8:0]  live_n;
	map_t        live_map;
	map_t        free_map;
	logic [2:0]  pick_word_d;
	logic [31:0] pick_bits_d;
	logic        pick_any_d;
	logic [31:0] low_bit;
	logic [4:0]  low_pos;
	logic [7:0]  grant_slot_d;
	logic [31:0] hdr_addr;
	logic        chk_range;
	logic        chk_used;
	logic        chk_cmpl;
	logic        chk_ok;
	logic [31:0] chk_mask;
	cst_pkg::cst_result_t res_d;

	assign done   = res_vld_q;
	assign result = res_q;

	// Effective slot count and the mask of live slots.
	assign live_n = (cfg.slot_count > MAX_N) ? MAX_N : cfg.slot_count;

	always_comb begin
		for (int w = 0; w < MAP_WORDS; w++) begin
			for (int j = 0; j < 32; j++) begin
				live_map[w][j] = (9'(w * 32 + j) < live_n);
			end
		end
	end

	// Free live slots per word, and the lowest word that has one.
	always_comb begin
		free_map    = ~used_map_q & live_map;
		pick_word_d = 3'd0;
		pick_bits_d = 32'd0;
		pick_any_d  = 1'b0;
		for (int w = MAP_WORDS - 1; w >= 0; w--) begin
			if (|free_map[w]) begin
				pick_word_d = 3'(w);
				pick_bits_d = free_map[w];
				pick_any_d  = 1'b1;
			end
		end
	end

	// Lowest free bit within the chosen word.
	always_comb begin
		low_bit = pick_bits_s1 & (~pick_bits_s1 + 32'd1);
		low_pos = 5'd0;
		for (int j = 0; j < 32; j++) begin
			if (low_bit[j]) begin
				low_pos = low_pos | 5'(j);
			end
		end
		grant_slot_d = {pick_word_s1, low_pos};
	end

	// Lookup of the slot named by a check transaction.
	always_comb begin
		chk_range = ({1'b0, item_q.slot} < MAX_N);
		chk_used  = 1'b0;
		chk_cmpl  = 1'b0;
		for (int w = 0; w < MAP_WORDS; w++) begin
			if (3'(w) == item_q.slot[7:5]) begin
				chk_used = used_map_q[w][item_q.slot[4:0]];
				chk_cmpl = cmpl_map_q[w][item_q.slot[4:0]];
			end
		end
		chk_ok   = chk_range & chk_used & chk_cmpl;
		chk_mask = 32'd1 << item_q.slot[4:0];
	end

	// Result formation; fields not named for a case stay zero.
	assign hdr_addr = cfg.queue_base + {7'd0, prod_s2};

	always_comb begin
		res_d = '0;
		if (cmd.addr && grant_any_s2) begin
			res_d.ok             = 1'b1;
			res_d.granted_slot   = grant_slot_s2;
			res_d.header_address = hdr_addr;
			res_d.data_address   = hdr_addr + 32'd4;
			if (cfg.doorbell_enable) begin
				res_d.doorbell_valid = 1'b1;
				res_d.doorbell_index = grant_slot_s2[7:5];
				res_d.doorbell_mask  = 32'd1 << grant_slot_s2[4:0];
			end
		end else if (cmd.merge) begin
			res_d.ok = 1'b1;
		end else if (cmd.check) begin
			res_d.ok = chk_ok;
		end
	end

	// Slot maps: set on grant, merge on status, clear on successful check.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_map_q <= '0;
			cmpl_map_q <= '0;
		end else begin
			for (int w = 0; w < MAP_WORDS; w++) begin
				if (cmd.grant && pick_any_s1 && (3'(w) == pick_word_s1)) begin
					used_map_q[w] <= used_map_q[w] | low_bit;
				end
				if (cmd.merge) begin
					cmpl_map_q[w] <= (cmpl_map_q[w] |
						((3'(w) == item_q.word_index) ? item_q.status_bits : 32'd0)) &
						live_map[w];
				end
				if (cmd.check && chk_ok && (3'(w) == item_q.slot[7:5])) begin
					used_map_q[w] <= used_map_q[w] & ~chk_mask;
					cmpl_map_q[w] <= cmpl_map_q[w] & ~chk_mask;
				end
			end
		end
	end

	// Input capture and search pipeline payload.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.pick) begin
			pick_word_s1 <= pick_word_d;
			pick_bits_s1 <= pick_bits_d;
			pick_any_s1  <= pick_any_d;
		end
		if (cmd.grant) begin
			grant_slot_s2 <= grant_slot_d;
			grant_any_s2  <= pick_any_s1;
			prod_s2       <= cfg.slot_bytes * grant_slot_d;
		end
		if (cmd.addr || cmd.merge || cmd.check || cmd.nop) begin
			res_q <= res_d;
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else begin
			res_vld_q <= cmd.addr | cmd.merge | cmd.check | cmd.nop;
		end
	end

	// A granted slot adds exactly one bit to the used map.
	`CST_ASSERT_NEXT(a_grant_one_bit, cmd.grant && pick_any_s1, $countones(used_map_q) == $past($countones(used_map_q)) + 1)
	// After a merge no completion bit stays at or above the slot count.
	`CST_ASSERT_NEXT(a_merge_trims, cmd.merge, (cmpl_map_q & ~live_map) == '0)
	// A doorbell is only offered with a granted slot.
	`CST_ASSERT_IMPL(a_doorbell_ok, res_vld_q && res_q.doorbell_valid, res_q.ok)

endmodule

[rtl/command_slot_tracker_top.sv]
// ---------------------------------------------------------------------------
// Command slot tracker
// Allocates command-queue slots from a used map and retires them against a
// completion map fed by status words.
// ---------------------------------------------------------------------------
//  Channel   Handshake                      Payload
//  config    psel/penable/pwrite, pready    paddr, pwdata, prdata
//  command   start, accepted when !busy     item (cst_item_t)
//  result    done strobe, one cycle         result (cst_result_t)
//
// An allocate transaction passes slot search, priority encode with the size
// multiply, address add and result register before its strobe; status, check
// and unknown actions run only their own step. busy is low again in the cycle
// the result is shown, so a new transaction can enter then.
// Reset clears both slot maps at once and loads the register defaults.
// The result has no back-pressure: it must be taken in its strobe cycle.
// ---------------------------------------------------------------------------
module command_slot_tracker_top #(
	parameter int SLOT_LIMIT = cst_pkg::SLOT_LIMIT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 start,
	output logic                 busy,
	input  cst_pkg::cst_item_t   item,
	output logic                 done,
	output cst_pkg::cst_result_t result
);

	cst_pkg::cst_cfg_t cfg;
	cst_pkg::cst_cmd_t cmd;

	// Configuration registers.
	cst_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer.
	cst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (item.action),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Slot maps and result datapath.
	cst_dpath #(
		.SLOT_LIMIT (SLOT_LIMIT)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cfg    (cfg),
		.item   (item),
		.done   (done),
		.result (result)
	);

endmodule
